// ===== rtl/glat_pkg.sv =====
// glat_pkg: types, codes and constants of the GF(2^m) log/antilog table builder.
// No dependencies; imported by glat_build_ctrl and the top level.
`timescale 1ns / 1ps

package glat_pkg;

   localparam int MAX_ORDER = 16;
   localparam int ELEM_W    = 16;
   localparam int POLY_W    = 17;
   localparam int ORDER_W   = 5;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_ORDER      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_POLYNOMIAL = 1'd1;

   localparam logic OP_BUILD  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_DEG   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_PRIM  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 3'd4;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd8;
   localparam logic [POLY_W-1:0]  POLY_RESET  = 17'd0;

   typedef struct packed {
      logic              operation;
      logic [ELEM_W-1:0] element;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ELEM_W-1:0]   log_value;
      logic [ELEM_W-1:0]   power_value;
   } rsp_type;

   // table write ports driven by the build sequencer
   typedef struct packed {
      logic              log_we;
      logic [ELEM_W-1:0] log_addr;
      logic [ELEM_W-1:0] log_data;
      logic              pow_we;
      logic [ELEM_W-1:0] pow_addr;
      logic [ELEM_W-1:0] pow_data;
   } tbl_wr_type;

   // sequencer status towards the top level
   typedef struct packed {
      logic                busy;
      logic                res_valid;
      logic [STATUS_W-1:0] res_status;
      logic                field_good;
      logic [ORDER_W-1:0]  built_order;
   } bld_info_type;

   typedef enum logic [2:0] {
      BLD_IDLE,
      BLD_CHECK,
      BLD_INIT,
      BLD_WALK,
      BLD_DONE
   } bld_state_type;

   function automatic logic [POLY_W-1:0] default_poly(input logic [3:0] idx);
      logic [POLY_W-1:0] p;
      case (idx)
         4'd0:    p = 17'h00003;
         4'd1:    p = 17'h00007;
         4'd2:    p = 17'h0000b;
         4'd3:    p = 17'h00013;
         4'd4:    p = 17'h00025;
         4'd5:    p = 17'h00043;
         4'd6:    p = 17'h00089;
         4'd7:    p = 17'h0011d;
         4'd8:    p = 17'h00211;
         4'd9:    p = 17'h00409;
         4'd10:   p = 17'h00805;
         4'd11:   p = 17'h01053;
         4'd12:   p = 17'h0201b;
         4'd13:   p = 17'h04443;
         4'd14:   p = 17'h08003;
         4'd15:   p = 17'h1100b;
         default: p = 17'h00003;
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/glat_table_ram.sv =====
// glat_table_ram: simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module glat_table_ram #(
   parameter int DATA_W = 16,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [(1 << ADDR_W)];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/glat_build_ctrl.sv =====
// glat_build_ctrl: build sequencer; checks order and polynomial, walks the Galois LFSR
// and writes both tables. Depends on glat_pkg.
`timescale 1ns / 1ps

module glat_build_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [glat_pkg::ORDER_W-1:0]  cfg_order,
   input  logic [glat_pkg::POLY_W-1:0]   cfg_poly,
   input  logic                          slot_free,
   output glat_pkg::tbl_wr_type          tbl_wr,
   output glat_pkg::bld_info_type        info
);
   import glat_pkg::*;

   bld_state_type state_ff, state_in;

   logic [ORDER_W-1:0]  m_ff;
   logic [POLY_W-1:0]   poly_ff;
   logic [ELEM_W-1:0]   n_ff;
   logic [ELEM_W-1:0]   reg_ff;
   logic [ELEM_W-1:0]   idx_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                good_ff;
   logic [ORDER_W-1:0]  built_ff;

   logic                ord_bad;
   logic                deg_bad;
   logic [POLY_W:0]     keep_mask;
   logic [POLY_W-1:0]   poly_eff;
   logic [ELEM_W-1:0]   n_calc;
   logic [POLY_W-1:0]   shifted;
   logic [ELEM_W-1:0]   reg_next;
   logic                walk_early;
   logic                walk_last;

   assign ord_bad   = (m_ff == '0) || (m_ff > ORDER_W'(MAX_ORDER));
   assign keep_mask = (POLY_W+1)'(((POLY_W+1)'(1) << (m_ff + 5'd1)) - (POLY_W+1)'(1));
   assign deg_bad   = (poly_ff != '0) &&
                      ((|({1'b0, poly_ff} & ~keep_mask)) || !poly_ff[m_ff]);
   assign poly_eff  = (poly_ff == '0) ? default_poly(4'(m_ff - 5'd1)) : poly_ff;
   assign n_calc    = ELEM_W'(((ELEM_W+1)'(1) << m_ff) - (ELEM_W+1)'(1));

   always_comb begin
      shifted = {reg_ff, 1'b0};
      if (shifted[m_ff]) begin
         shifted = shifted ^ poly_ff;
      end
   end
   assign reg_next   = shifted[ELEM_W-1:0] & n_ff;
   assign walk_early = (idx_ff != '0) && (reg_ff == ELEM_W'(1));
   assign walk_last  = (idx_ff == n_ff - ELEM_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BLD_IDLE: begin
            if (start) state_in = BLD_CHECK;
         end
         BLD_CHECK: begin
            state_in = (ord_bad || deg_bad) ? BLD_DONE : BLD_INIT;
         end
         BLD_INIT: begin
            state_in = BLD_WALK;
         end
         BLD_WALK: begin
            if (walk_early || walk_last) state_in = BLD_DONE;
         end
         BLD_DONE: begin
            if (slot_free) state_in = BLD_IDLE;
         end
         default: state_in = BLD_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      tbl_wr = '0;
      case (state_ff)
         BLD_INIT: begin
            tbl_wr.log_we   = 1'b1;
            tbl_wr.log_addr = '0;
            tbl_wr.log_data = n_ff;
            tbl_wr.pow_we   = 1'b1;
            tbl_wr.pow_addr = n_ff;
            tbl_wr.pow_data = '0;
         end
         BLD_WALK: begin
            tbl_wr.log_we   = 1'b1;
            tbl_wr.log_addr = reg_ff;
            tbl_wr.log_data = idx_ff;
            tbl_wr.pow_we   = 1'b1;
            tbl_wr.pow_addr = idx_ff;
            tbl_wr.pow_data = reg_ff;
         end
         default: tbl_wr = '0;
      endcase
      info.busy        = (state_ff != BLD_IDLE);
      info.res_valid   = (state_ff == BLD_DONE);
      info.res_status  = status_ff;
      info.field_good  = good_ff;
      info.built_order = built_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BLD_IDLE;
         good_ff  <= 1'b0;
         built_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BLD_CHECK) begin
            good_ff <= 1'b0;
         end
         if ((state_ff == BLD_WALK) && !walk_early && walk_last &&
             (reg_next == ELEM_W'(1))) begin
            good_ff  <= 1'b1;
            built_ff <= m_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BLD_IDLE: begin
            if (start) begin
               m_ff    <= cfg_order;
               poly_ff <= cfg_poly;
            end
         end
         BLD_CHECK: begin
            poly_ff <= poly_eff;
            n_ff    <= n_calc;
            reg_ff  <= ELEM_W'(1);
            idx_ff  <= '0;
            if (ord_bad) begin
               status_ff <= ST_BAD_ORDER;
            end else if (deg_bad) begin
               status_ff <= ST_BAD_DEG;
            end
         end
         BLD_WALK: begin
            reg_ff <= reg_next;
            idx_ff <= idx_ff + ELEM_W'(1);
            if (walk_early) begin
               status_ff <= ST_NOT_PRIM;
            end else if (walk_last) begin
               status_ff <= (reg_next == ELEM_W'(1)) ? ST_OK : ST_NOT_PRIM;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/gf2m_log_antilog_table_builder.sv =====
// gf2m_log_antilog_table_builder: top level; configuration registers, both table RAMs,
// build sequencer and the lookup/response path. Depends on glat_pkg, glat_table_ram,
// glat_build_ctrl.
//
//   channel  direction  payload              transfer when
//   req      in         req_type (op, elem)  req_valid && !req_stall
//   rsp      out        rsp_type             rsp_valid && !rsp_stall
//   csr      in         index, 17-bit data   csr_we
//
// Lookup: one per cycle while rsp is not stalled and no build runs; the result goes
// through the table RAM read register, then the output register. Build: the order and
// polynomial are checked, then the LFSR walk writes one entry of each table per cycle;
// it stops early when a check fails or the LFSR returns to 1 early. req is stalled until
// the build result leaves the sequencer. Reset is synchronous and leaves the tables
// unwritten; status reads "not built" until a good build. A stalled rsp holds the read
// stage and then stalls req.
`timescale 1ns / 1ps

module gf2m_log_antilog_table_builder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  glat_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output glat_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [glat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [glat_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import glat_pkg::*;

   logic [ORDER_W-1:0]  field_order_ff;
   logic [POLY_W-1:0]   field_polynomial_ff;

   tbl_wr_type          tbl_wr;
   bld_info_type        info;

   logic                p1_valid_ff;
   logic                p1_lookup_ff;
   logic [STATUS_W-1:0] p1_status_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                advance;
   logic                slot_free;
   logic                req_xfer;
   logic                build_start;
   logic                lookup_rd;
   logic                build_take;
   logic [ELEM_W-1:0]   elem_mask;
   logic [ELEM_W-1:0]   rd_addr;
   logic [ELEM_W-1:0]   log_rdata;
   logic [ELEM_W-1:0]   pow_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_order_ff      <= ORDER_RESET;
         field_polynomial_ff <= POLY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIELD_ORDER:      field_order_ff      <= csr_wdata[ORDER_W-1:0];
            CSR_FIELD_POLYNOMIAL: field_polynomial_ff <= csr_wdata[POLY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance     = p1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign slot_free   = !p1_valid_ff || advance;
   assign req_stall   = info.busy || (p1_valid_ff && !advance);
   assign req_xfer    = req_valid && !req_stall;
   assign build_start = req_xfer && (req_data.operation == OP_BUILD);
   assign lookup_rd   = req_xfer && (req_data.operation == OP_LOOKUP);
   assign build_take  = info.res_valid && slot_free;

   assign elem_mask = ELEM_W'(((ELEM_W+1)'(1) << info.built_order) - (ELEM_W+1)'(1));
   assign rd_addr   = req_data.element & elem_mask;

   glat_build_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (build_start),
      .cfg_order (field_order_ff),
      .cfg_poly  (field_polynomial_ff),
      .slot_free (slot_free),
      .tbl_wr    (tbl_wr),
      .info      (info)
   );

   glat_table_ram #(.DATA_W(ELEM_W), .ADDR_W(ELEM_W)) u_log_ram (
      .clock (clock),
      .we    (tbl_wr.log_we),
      .waddr (tbl_wr.log_addr),
      .wdata (tbl_wr.log_data),
      .re    (lookup_rd),
      .raddr (rd_addr),
      .rdata (log_rdata)
   );

   glat_table_ram #(.DATA_W(ELEM_W), .ADDR_W(ELEM_W)) u_pow_ram (
      .clock (clock),
      .we    (tbl_wr.pow_we),
      .waddr (tbl_wr.pow_addr),
      .wdata (tbl_wr.pow_data),
      .re    (lookup_rd),
      .raddr (rd_addr),
      .rdata (pow_rdata)
   );

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (lookup_rd || build_take) begin
         p1_valid_ff <= 1'b1;
      end else if (advance) begin
         p1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (lookup_rd) begin
         p1_lookup_ff <= 1'b1;
         p1_status_ff <= info.field_good ? ST_OK : ST_NOT_BUILT;
      end else if (build_take) begin
         p1_lookup_ff <= 1'b0;
         p1_status_ff <= info.res_status;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.status <= p1_status_ff;
         if (p1_lookup_ff && (p1_status_ff == ST_OK)) begin
            rsp_data_ff.log_value   <= log_rdata;
            rsp_data_ff.power_value <= pow_rdata;
         end else begin
            rsp_data_ff.log_value   <= '0;
            rsp_data_ff.power_value <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      !info.busy |-> (!tbl_wr.log_we && !tbl_wr.pow_we))
      else $error("table write outside a build");

   a_ok_sets_good: assert property (@(posedge clock) disable iff (reset)
      (build_take && (info.res_status == ST_OK)) |-> info.field_good)
      else $error("good build result without field_good");

   a_read_not_building: assert property (@(posedge clock) disable iff (reset)
      lookup_rd |-> !info.busy)
      else $error("table read during a build");

   a_fail_clears_good: assert property (@(posedge clock) disable iff (reset)
      (build_take && (info.res_status != ST_OK)) |-> !info.field_good)
      else $error("failed build left field_good set");

endmodule
